FILE: design/dcr_pkg.sv
// ---------------------------------------------------------------------------
// dcr_pkg
// Shared types, widths and codes of the grid ray caster.
// ---------------------------------------------------------------------------
`default_nettype none

package dcr_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int SAT31     = 32'h7FFF_FFFF;

  // arithmetic unit widths
  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 34;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 31;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  // datapath widths
  localparam int CAM_W   = 31;
  localparam int RAY_W   = 34;
  localparam int DELTA_W = 31;
  localparam int SD_W    = 44;
  localparam int COORD_W = 10;
  localparam int LINE_W  = 16;
  localparam int WC_W    = MUL_P_W + 2;

  localparam logic [DIV_NUM_W-1:0] RECIP_NUM = DIV_NUM_W'(1) << (2 * FRAC_BITS);
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;
  localparam logic [LINE_W-1:0] LINE_BOUND_MULT = 16'd10;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // register indexes
  localparam logic [2:0] CFG_POS_X        = 3'd0;
  localparam logic [2:0] CFG_POS_Y        = 3'd1;
  localparam logic [2:0] CFG_DIR_X        = 3'd2;
  localparam logic [2:0] CFG_DIR_Y        = 3'd3;
  localparam logic [2:0] CFG_PLANE_X      = 3'd4;
  localparam logic [2:0] CFG_PLANE_Y      = 3'd5;
  localparam logic [2:0] CFG_SCREEN_WIDTH = 3'd6;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd7;

  // hit side and wall face codes
  localparam logic SIDE_X = 1'b0;
  localparam logic SIDE_Y = 1'b1;
  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_NORTH = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM,
    ST_RX,
    ST_RY,
    ST_DDX,
    ST_DDY,
    ST_SDX,
    ST_SDY,
    ST_STEP,
    ST_TEST,
    ST_LINE,
    ST_WC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

FILE: design/dcr_map_ram.sv
// ---------------------------------------------------------------------------
// dcr_map_ram
// One-bit wall map memory, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module dcr_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic               rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/dcr_divider.sv
// ---------------------------------------------------------------------------
// dcr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dcr_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dcr_pkg::div_req_t            req,
  output logic                              done,
  output logic [dcr_pkg::DIV_NUM_W-1:0]     quot
);
  import dcr_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W:0]   rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_DEN_W:0]   trial;

  always_comb begin
    trial = {rem_r[DIV_DEN_W-1:0], quo_r[DIV_NUM_W-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

FILE: design/dcr_multiplier.sv
// ---------------------------------------------------------------------------
// dcr_multiplier
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dcr_multiplier (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dcr_pkg::mul_req_t          req,
  output logic                            done,
  output logic [dcr_pkg::MUL_P_W-1:0]     prod
);
  import dcr_pkg::*;

  localparam int CW = $clog2(MUL_B_W + 1);

  logic [MUL_P_W-1:0] acc_r, a_sh_r;
  logic [MUL_B_W-1:0] b_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MUL_B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r  <= '0;
      a_sh_r <= MUL_P_W'(req.a);
      b_r    <= req.b;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_sh_r;
      end
      a_sh_r <= a_sh_r << 1;
      b_r    <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

FILE: design/dda_column_raycaster.sv
// ---------------------------------------------------------------------------
// dda_column_raycaster
// Grid ray caster: wall map in memory, one screen column cast per request.
// ---------------------------------------------------------------------------
// a map write request is written to the map as it is taken; a cast request
//   is paced by the shared bit-serial divider (4 divides) and multiplier
//   (5 products) and by the map read of each grid step (at most MAX_STEPS
//   steps)
// throughput: one request at a time; a finished result waits in the output
//   register while the next request is taken
// reset: synchronous; the map memory is then cleared in a pass over all
//   MAP_ROWS*MAP_STRIDE cells during which no request is taken
// ---------------------------------------------------------------------------
`default_nettype none

module dda_column_raycaster #(
  parameter int MAP_STRIDE = 64,
  parameter int MAP_ROWS   = 64,
  parameter int MAX_STEPS  = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [11:0] in_column,
  input  wire logic [5:0]  in_cell_row,
  input  wire logic [5:0]  in_cell_col,
  input  wire logic        in_cell_wall,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_column,
  output logic [11:0]      out_span_top,
  output logic [11:0]      out_span_bottom,
  output logic             out_hit_side,
  output logic [1:0]       out_wall_face,
  output logic [30:0]      out_perp_distance,
  output logic [31:0]      out_wall_coord,
  output logic [5:0]       out_hit_map_x,
  output logic [5:0]       out_hit_map_y,
  output logic             out_no_hit,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [21:0] cfg_wdata
);
  import dcr_pkg::*;

  localparam int DEPTH = MAP_ROWS * MAP_STRIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_STEPS + 1);

  // configuration registers
  logic [21:0]        pos_x_r, pos_y_r;
  logic signed [18:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [12:0]        width_r, height_r;

  // sequencer
  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;
  logic [AW-1:0] clr_addr_r;

  // per-cast working registers
  logic [11:0]               col_r;
  logic signed [CAM_W-1:0]   cam_r;
  logic signed [RAY_W-1:0]   rx_r, ry_r;
  logic [DELTA_W-1:0]        ddx_r, ddy_r;
  logic [SD_W-1:0]           sdx_r, sdy_r;
  logic signed [COORD_W-1:0] mx_r, my_r;
  logic                      side_r, hit_r;
  logic [NW-1:0]             n_r;
  logic [30:0]               perp_r;
  logic [LINE_W-1:0]         line_r;
  logic [31:0]               wc_r;

  // output register
  logic        out_valid_r;
  logic [11:0] o_col_r, o_ds_r, o_de_r;
  logic        o_side_r, o_nohit_r;
  logic [1:0]  o_face_r;
  logic [30:0] o_perp_r;
  logic [31:0] o_wc_r;
  logic [5:0]  o_mx_r, o_my_r;

  // arithmetic units
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_NUM_W-1:0] div_q;
  mul_req_t           mul_req;
  logic               mul_neg;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_p;

  // map memory ports
  logic          ram_we, ram_wd, ram_rd;
  logic [AW-1:0] ram_wa, ram_ra;

  logic in_fire, out_free, write_in_map;

  // effective screen width and frame height
  logic [12:0]       w_eff, h_eff;
  logic [LINE_W-1:0] h10;

  // grid step candidates
  logic                      step_x, oob;
  logic signed [COORD_W-1:0] mx_new, my_new;
  logic [SD_W-1:0]           sdx_new, sdy_new;

  // signed product, floored to whole fixed point units
  logic signed [MUL_P_W:0] prod_s, prod_fl;

  logic [DIV_NUM_W-1:0] recip_sat;
  logic [SD_W-1:0]      perp_diff;
  logic [30:0]          perp_hit;
  logic [16:0]          frac_x, frac_y;
  logic [RAY_W-1:0]     abs_rx, abs_ry;
  logic [18:0]          abs_px, abs_py;
  logic [CAM_W-1:0]     abs_cam;
  logic signed [WC_W-1:0] wc_sum;
  logic [31:0]          wc_sat;
  logic [DIV_NUM_W-1:0] line_q;
  logic [LINE_W-1:0]    line_sel;

  // draw span
  logic [11:0]        half_h;
  logic [14:0]        half_l;
  logic signed [16:0] ds_s;
  logic [16:0]        de_u;
  logic [11:0]        ds, de;

  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign write_in_map = (int'(in_cell_row) < MAP_ROWS) && (int'(in_cell_col) < MAP_STRIDE);

  assign w_eff = (width_r == 13'd0) ? 13'd1 : width_r;
  assign h_eff = (height_r == 13'd0) ? 13'd1 :
                 ((height_r > MAX_HEIGHT) ? MAX_HEIGHT : height_r);
  assign h10   = LINE_W'(h_eff) * LINE_BOUND_MULT;

  // magnitudes feeding the unsigned multiplier and divider
  assign abs_px  = plane_x_r[18] ? 19'(-plane_x_r) : 19'(plane_x_r);
  assign abs_py  = plane_y_r[18] ? 19'(-plane_y_r) : 19'(plane_y_r);
  assign abs_cam = cam_r[CAM_W-1] ? CAM_W'(-cam_r) : CAM_W'(cam_r);
  assign abs_rx  = rx_r[RAY_W-1] ? RAY_W'(-rx_r) : RAY_W'(rx_r);
  assign abs_ry  = ry_r[RAY_W-1] ? RAY_W'(-ry_r) : RAY_W'(ry_r);

  // fraction of the start cell to the first edge crossed
  assign frac_x = rx_r[RAY_W-1] ? {1'b0, pos_x_r[15:0]} : 17'h10000 - {1'b0, pos_x_r[15:0]};
  assign frac_y = ry_r[RAY_W-1] ? {1'b0, pos_y_r[15:0]} : 17'h10000 - {1'b0, pos_y_r[15:0]};

  assign prod_s  = mul_neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
  assign prod_fl = prod_s >>> FRAC_BITS;

  assign recip_sat = (div_q > DIV_NUM_W'(SAT31)) ? DIV_NUM_W'(SAT31) : div_q;

  // one grid step: x when its side distance is strictly smaller
  always_comb begin
    step_x  = sdx_r < sdy_r;
    sdx_new = sdx_r;
    sdy_new = sdy_r;
    mx_new  = mx_r;
    my_new  = my_r;
    if (step_x) begin
      sdx_new = sdx_r + SD_W'(ddx_r);
      mx_new  = mx_r + (rx_r[RAY_W-1] ? {COORD_W{1'b1}} : COORD_W'(1));
    end else begin
      sdy_new = sdy_r + SD_W'(ddy_r);
      my_new  = my_r + (ry_r[RAY_W-1] ? {COORD_W{1'b1}} : COORD_W'(1));
    end
    oob = (mx_new < 0) || (int'(mx_new) >= MAP_STRIDE) ||
          (my_new < 0) || (int'(my_new) >= MAP_ROWS);
  end

  // perpendicular distance once the step that hit is in the registers
  assign perp_diff = (side_r == SIDE_Y) ? sdy_r - SD_W'(ddy_r) : sdx_r - SD_W'(ddx_r);
  assign perp_hit  = (perp_diff > SD_W'(SAT31)) ? 31'(SAT31) : perp_diff[30:0];

  // line height, bounded by ten times the frame height
  assign line_q   = (div_q > DIV_NUM_W'(h10)) ? DIV_NUM_W'(h10) : div_q;
  assign line_sel = LINE_W'(line_q);

  // wall coordinate along the other axis, saturated to 32 bits
  always_comb begin
    if (side_r == SIDE_X) begin
      wc_sum = WC_W'(prod_fl) + $signed(WC_W'(pos_y_r));
    end else begin
      wc_sum = WC_W'(prod_fl) + $signed(WC_W'(pos_x_r));
    end
    if (!wc_sum[WC_W-1] && (|wc_sum[WC_W-2:31])) begin
      wc_sat = 32'h7FFF_FFFF;
    end else if (wc_sum[WC_W-1] && !(&wc_sum[WC_W-2:31])) begin
      wc_sat = 32'h8000_0000;
    end else begin
      wc_sat = wc_sum[31:0];
    end
  end

  // draw span from the frame center
  assign half_h = h_eff[12:1];
  assign half_l = line_r[LINE_W-1:1];
  assign ds_s   = $signed({5'b0, half_h}) - $signed({2'b0, half_l});
  assign de_u   = 17'(half_h) + 17'(half_l);
  assign ds     = ds_s[16] ? 12'd0 : ds_s[11:0];
  assign de     = (de_u >= 17'(h_eff)) ? 12'(h_eff - 13'd1) : de_u[11:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (int'(clr_addr_r) == DEPTH - 1) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire && in_opcode == OP_CAST) state_nxt = ST_CAM;
      ST_CAM:   if (div_done) state_nxt = ST_RX;
      ST_RX:    if (mul_done) state_nxt = ST_RY;
      ST_RY:    if (mul_done) state_nxt = ST_DDX;
      ST_DDX:   if (rx_r == 0 || div_done) state_nxt = ST_DDY;
      ST_DDY:   if (ry_r == 0 || div_done) state_nxt = ST_SDX;
      ST_SDX:   if (mul_done) state_nxt = ST_SDY;
      ST_SDY:   if (mul_done) state_nxt = ST_STEP;
      ST_STEP: begin
        if (n_r == NW'(MAX_STEPS) || oob) state_nxt = ST_DONE;
        else state_nxt = ST_TEST;
      end
      ST_TEST:  state_nxt = ram_rd ? ST_LINE : ST_STEP;
      ST_LINE:  if (perp_r == 31'd0 || div_done) state_nxt = ST_WC;
      ST_WC:    if (mul_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // unit requests and memory ports
  always_comb begin
    div_req = '0;
    mul_req = '0;
    mul_neg = 1'b0;
    ram_we  = 1'b0;
    ram_wa  = clr_addr_r;
    ram_wd  = 1'b0;
    ram_ra  = AW'(int'(my_new) * MAP_STRIDE + int'(mx_new));
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_opcode == OP_WRITE && write_in_map) begin
          ram_we = 1'b1;
          ram_wa = AW'(int'(in_cell_row) * MAP_STRIDE + int'(in_cell_col));
          ram_wd = in_cell_wall;
        end
      end
      ST_CAM: begin
        div_req.start = !launched_r;
        div_req.num   = DIV_NUM_W'({col_r, 1'b0, 16'b0});
        div_req.den   = DIV_DEN_W'(w_eff);
      end
      ST_RX: begin
        mul_req.start = !launched_r;
        mul_req.a     = MUL_A_W'(abs_px);
        mul_req.b     = MUL_B_W'(abs_cam);
        mul_neg       = plane_x_r[18] ^ cam_r[CAM_W-1];
      end
      ST_RY: begin
        mul_req.start = !launched_r;
        mul_req.a     = MUL_A_W'(abs_py);
        mul_req.b     = MUL_B_W'(abs_cam);
        mul_neg       = plane_y_r[18] ^ cam_r[CAM_W-1];
      end
      ST_DDX: begin
        div_req.start = !launched_r && rx_r != 0;
        div_req.num   = RECIP_NUM;
        div_req.den   = DIV_DEN_W'(abs_rx);
      end
      ST_DDY: begin
        div_req.start = !launched_r && ry_r != 0;
        div_req.num   = RECIP_NUM;
        div_req.den   = DIV_DEN_W'(abs_ry);
      end
      ST_SDX: begin
        mul_req.start = !launched_r;
        mul_req.a     = MUL_A_W'(ddx_r);
        mul_req.b     = MUL_B_W'(frac_x);
      end
      ST_SDY: begin
        mul_req.start = !launched_r;
        mul_req.a     = MUL_A_W'(ddy_r);
        mul_req.b     = MUL_B_W'(frac_y);
      end
      ST_LINE: begin
        div_req.start = !launched_r && perp_r != 31'd0;
        div_req.num   = DIV_NUM_W'({h_eff, 16'b0});
        div_req.den   = DIV_DEN_W'(perp_r);
      end
      ST_WC: begin
        mul_req.start = !launched_r;
        mul_req.a     = (side_r == SIDE_X) ? MUL_A_W'(abs_ry) : MUL_A_W'(abs_rx);
        mul_req.b     = MUL_B_W'(perp_r);
        mul_neg       = (side_r == SIDE_X) ? ry_r[RAY_W-1] : rx_r[RAY_W-1];
      end
      default: ;
    endcase
  end

  assign launched_nxt = (state_nxt != state_r) ? 1'b0 :
                        (launched_r | div_req.start | mul_req.start);

  dcr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  dcr_multiplier u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_p)
  );

  dcr_map_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      launched_r  <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      pos_x_r     <= 22'd0;
      pos_y_r     <= 22'd0;
      dir_x_r     <= 19'sd65536;
      dir_y_r     <= 19'sd0;
      plane_x_r   <= 19'sd0;
      plane_y_r   <= 19'sd43254;
      width_r     <= 13'd640;
      height_r    <= 13'd480;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_POS_X:        pos_x_r   <= cfg_wdata;
          CFG_POS_Y:        pos_y_r   <= cfg_wdata;
          CFG_DIR_X:        dir_x_r   <= cfg_wdata[18:0];
          CFG_DIR_Y:        dir_y_r   <= cfg_wdata[18:0];
          CFG_PLANE_X:      plane_x_r <= cfg_wdata[18:0];
          CFG_PLANE_Y:      plane_y_r <= cfg_wdata[18:0];
          CFG_SCREEN_WIDTH: width_r   <= cfg_wdata[12:0];
          CFG_FRAME_HEIGHT: height_r  <= cfg_wdata[12:0];
          default: ;
        endcase
      end
    end
  end

  // cast datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          col_r <= in_column;
          hit_r <= 1'b0;
          n_r   <= '0;
          mx_r  <= COORD_W'(pos_x_r[21:16]);
          my_r  <= COORD_W'(pos_y_r[21:16]);
        end
      end
      ST_CAM: if (div_done) cam_r <= $signed(CAM_W'(div_q)) - CAM_W'(32'h1_0000);
      ST_RX:  if (mul_done) rx_r <= $signed(prod_fl[RAY_W-1:0]) + RAY_W'(dir_x_r);
      ST_RY:  if (mul_done) ry_r <= $signed(prod_fl[RAY_W-1:0]) + RAY_W'(dir_y_r);
      ST_DDX: begin
        if (rx_r == 0) ddx_r <= DELTA_W'(SAT31);
        else if (div_done) ddx_r <= DELTA_W'(recip_sat);
      end
      ST_DDY: begin
        if (ry_r == 0) ddy_r <= DELTA_W'(SAT31);
        else if (div_done) ddy_r <= DELTA_W'(recip_sat);
      end
      ST_SDX: if (mul_done) sdx_r <= SD_W'(mul_p >> FRAC_BITS);
      ST_SDY: if (mul_done) sdy_r <= SD_W'(mul_p >> FRAC_BITS);
      ST_STEP: begin
        if (n_r != NW'(MAX_STEPS)) begin
          n_r    <= n_r + NW'(1);
          sdx_r  <= sdx_new;
          sdy_r  <= sdy_new;
          mx_r   <= mx_new;
          my_r   <= my_new;
          side_r <= step_x ? SIDE_X : SIDE_Y;
        end
      end
      ST_TEST: begin
        if (ram_rd) begin
          hit_r  <= 1'b1;
          perp_r <= perp_hit;
        end
      end
      ST_LINE: begin
        if (perp_r == 31'd0) line_r <= h10;
        else if (div_done) line_r <= line_sel;
      end
      ST_WC: if (mul_done) wc_r <= wc_sat;
      default: ;
    endcase
  end

  // result register, zero fields when the ray missed
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      o_col_r   <= col_r;
      o_nohit_r <= !hit_r;
      if (hit_r) begin
        o_ds_r   <= ds;
        o_de_r   <= de;
        o_side_r <= side_r;
        if (side_r == SIDE_X) begin
          o_face_r <= (!rx_r[RAY_W-1] && rx_r != 0) ? FACE_EAST : FACE_WEST;
        end else begin
          o_face_r <= (!ry_r[RAY_W-1] && ry_r != 0) ? FACE_NORTH : FACE_SOUTH;
        end
        o_perp_r <= perp_r;
        o_wc_r   <= wc_r;
        o_mx_r   <= mx_r[5:0];
        o_my_r   <= my_r[5:0];
      end else begin
        o_ds_r   <= '0;
        o_de_r   <= '0;
        o_side_r <= 1'b0;
        o_face_r <= '0;
        o_perp_r <= '0;
        o_wc_r   <= '0;
        o_mx_r   <= '0;
        o_my_r   <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column        = o_col_r;
  assign out_span_top      = o_ds_r;
  assign out_span_bottom   = o_de_r;
  assign out_hit_side      = o_side_r;
  assign out_wall_face     = o_face_r;
  assign out_perp_distance = o_perp_r;
  assign out_wall_coord    = o_wc_r;
  assign out_hit_map_x     = o_mx_r;
  assign out_hit_map_y     = o_my_r;
  assign out_no_hit        = o_nohit_r;

endmodule

`default_nettype wire
